// File: hdl/assert_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/modexp_pkg.sv
`default_nettype none

package modexp_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FIELD_BITS    = 32;
    localparam int INDEX_BITS    = 2;

    localparam logic [INDEX_BITS-1:0] REG_MODULUS  = 2'd0;
    localparam logic [INDEX_BITS-1:0] REG_EXPONENT = 2'd1;

    typedef logic [2:0] step_t;

    localparam step_t STEP_IDLE     = 3'd0;
    localparam step_t STEP_REDUCE   = 3'd1;
    localparam step_t STEP_SET_ACC  = 3'd2;
    localparam step_t STEP_MUL_ACC  = 3'd3;
    localparam step_t STEP_SET_SQR  = 3'd4;
    localparam step_t STEP_MUL_SQR  = 3'd5;
    localparam step_t STEP_NEXT_BIT = 3'd6;
    localparam step_t STEP_EMIT     = 3'd7;

    typedef enum logic [2:0] {
        OP_START,
        OP_REDUCE,
        OP_SET_ACC,
        OP_MUL_ACC,
        OP_SET_SQR,
        OP_MUL_SQR,
        OP_NEXT_BIT,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_REQ,
        COND_MUL_DONE,
        COND_EXP_BIT,
        COND_LAST_BIT,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t on_true;
        step_t on_false;
    } ctl_t;

    // microprogram: one control word per step
    function automatic ctl_t ucode(input step_t pc);
        ctl_t w;
        case (pc)
            STEP_IDLE:     w = '{OP_START,    COND_REQ,      STEP_REDUCE,  STEP_IDLE};
            STEP_REDUCE:   w = '{OP_REDUCE,   COND_MUL_DONE, STEP_SET_ACC, STEP_REDUCE};
            STEP_SET_ACC:  w = '{OP_SET_ACC,  COND_EXP_BIT,  STEP_MUL_ACC, STEP_SET_SQR};
            STEP_MUL_ACC:  w = '{OP_MUL_ACC,  COND_MUL_DONE, STEP_SET_SQR, STEP_MUL_ACC};
            STEP_SET_SQR:  w = '{OP_SET_SQR,  COND_ALWAYS,   STEP_MUL_SQR, STEP_MUL_SQR};
            STEP_MUL_SQR:  w = '{OP_MUL_SQR,  COND_MUL_DONE, STEP_NEXT_BIT, STEP_MUL_SQR};
            STEP_NEXT_BIT: w = '{OP_NEXT_BIT, COND_LAST_BIT, STEP_EMIT,    STEP_SET_ACC};
            STEP_EMIT:     w = '{OP_EMIT,     COND_OUT_FREE, STEP_IDLE,    STEP_EMIT};
            default:       w = '{OP_START,    COND_REQ,      STEP_REDUCE,  STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: hdl/modexp_cfg_if.sv
`default_nettype none

interface modexp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [modexp_pkg::INDEX_BITS-1:0]   index;
    logic [modexp_pkg::FIELD_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/modexp_in_if.sv
`default_nettype none

interface modexp_in_if;
    logic                              valid;
    logic                              ready;
    logic [modexp_pkg::FIELD_BITS-1:0] base;

    modport source (output valid, output base, input ready);
    modport sink (input valid, input base, output ready);
endinterface

`default_nettype wire

// File: hdl/modexp_out_if.sv
`default_nettype none

interface modexp_out_if;
    logic                              valid;
    logic                              ready;
    logic [modexp_pkg::FIELD_BITS-1:0] power_mod;

    modport source (output valid, output power_mod, input ready);
    modport sink (input valid, input power_mod, output ready);
endinterface

`default_nettype wire

// File: hdl/modular_exponentiation.sv
// modular exponentiation: power_mod = base ^ exponent mod modulus
// cfg: register writes, index 0 modulus, index 1 exponent, other indexes ignored;
//   taken only while the sequencer is idle; a modulus of zero acts as one
// operand: one base per request; result: one power_mod per request
// a microcoded sequencer drives one shared doubling modular multiplier:
//   each modular product handles one multiplier bit per cycle
// per request: reduce the base, then scan all WORD_BITS exponent bits from the
//   lowest, squaring for every bit and multiplying in for each one bit
// one request at a time; the next is taken in the cycle after the result is
//   loaded into the output register, so a stalled receiver holds back only the
//   following result, never the one already waiting
// reset: modulus and exponent return to 1, no result is pending
`default_nettype none

module modular_exponentiation #(
    parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    modexp_cfg_if.sink         cfg,
    modexp_in_if.sink          operand,
    modexp_out_if.source       result
);

    localparam int CNT_BITS = $clog2(WORD_BITS);
    localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(WORD_BITS - 1);

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    function automatic word_t add_mod(input word_t a, input word_t b, input word_t m);
        word_t room;
        room = m - b;
        return (a >= room) ? (a - room) : (a + b);
    endfunction

    modexp_pkg::step_t pc_reg, pc_next;
    logic              out_valid_reg, out_valid_next;
    cnt_t              mcnt_reg, mcnt_next;
    cnt_t              ecnt_reg, ecnt_next;
    word_t             modulus_reg, modulus_next;
    word_t             exponent_reg, exponent_next;

    word_t             prod_reg, prod_next;
    word_t             x_reg, x_next;
    word_t             y_reg, y_next;
    word_t             acc_reg, acc_next;
    word_t             pw_reg, pw_next;
    word_t             exp_reg, exp_next;
    logic [modexp_pkg::FIELD_BITS-1:0] out_data_reg, out_data_next;

    modexp_pkg::ctl_t  ctl;
    logic              cond_ok;
    logic              mul_done;
    logic              out_free;
    logic              req_fire;
    logic              cfg_fire;
    word_t             m_eff;
    word_t             one_mod;
    word_t             prod_step;
    word_t             x_step;

    assign ctl       = modexp_pkg::ucode(pc_reg);
    assign m_eff     = (modulus_reg == '0) ? word_t'(1) : modulus_reg;
    assign one_mod   = (modulus_reg <= word_t'(1)) ? '0 : word_t'(1);
    assign mul_done  = (mcnt_reg == LAST_CNT);
    assign prod_step = y_reg[0] ? add_mod(prod_reg, x_reg, m_eff) : prod_reg;
    assign x_step    = add_mod(x_reg, x_reg, m_eff);
    assign out_free  = !out_valid_reg || result.ready;

    // config wins over a new request in the same cycle
    assign cfg.ready     = (pc_reg == modexp_pkg::STEP_IDLE);
    assign operand.ready = (pc_reg == modexp_pkg::STEP_IDLE) && !cfg.valid;
    assign req_fire      = operand.valid && operand.ready;
    assign cfg_fire      = cfg.valid && cfg.ready;

    assign result.valid     = out_valid_reg;
    assign result.power_mod = out_data_reg;

    always_comb
    begin
        case (ctl.cond)
            modexp_pkg::COND_ALWAYS:   cond_ok = 1'b1;
            modexp_pkg::COND_REQ:      cond_ok = req_fire;
            modexp_pkg::COND_MUL_DONE: cond_ok = mul_done;
            modexp_pkg::COND_EXP_BIT:  cond_ok = exp_reg[0];
            modexp_pkg::COND_LAST_BIT: cond_ok = (ecnt_reg == LAST_CNT);
            modexp_pkg::COND_OUT_FREE: cond_ok = out_free;
            default:                   cond_ok = 1'b1;
        endcase
        pc_next = cond_ok ? ctl.on_true : ctl.on_false;
    end

    always_comb
    begin
        modulus_next   = modulus_reg;
        exponent_next  = exponent_reg;
        out_valid_next = result.ready ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;
        mcnt_next      = mcnt_reg;
        ecnt_next      = ecnt_reg;
        prod_next      = prod_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        acc_next       = acc_reg;
        pw_next        = pw_reg;
        exp_next       = exp_reg;

        if (cfg_fire)
        begin
            if (cfg.index == modexp_pkg::REG_MODULUS)
            begin
                modulus_next = word_t'(cfg.data);
            end
            else if (cfg.index == modexp_pkg::REG_EXPONENT)
            begin
                exponent_next = word_t'(cfg.data);
            end
        end

        case (ctl.op)
            modexp_pkg::OP_START:
            begin
                if (req_fire)
                begin
                    // base mod m as (1 mod m) times base
                    x_next    = one_mod;
                    y_next    = word_t'(operand.base);
                    prod_next = '0;
                    acc_next  = one_mod;
                    exp_next  = exponent_reg;
                    ecnt_next = '0;
                    mcnt_next = '0;
                end
            end
            modexp_pkg::OP_REDUCE, modexp_pkg::OP_MUL_ACC, modexp_pkg::OP_MUL_SQR:
            begin
                prod_next = prod_step;
                x_next    = x_step;
                y_next    = y_reg >> 1;
                mcnt_next = mul_done ? '0 : mcnt_reg + cnt_t'(1);
                if (mul_done)
                begin
                    if (ctl.op == modexp_pkg::OP_MUL_ACC)
                    begin
                        acc_next = prod_step;
                    end
                    else
                    begin
                        pw_next = prod_step;
                    end
                end
            end
            modexp_pkg::OP_SET_ACC:
            begin
                x_next    = acc_reg;
                y_next    = pw_reg;
                prod_next = '0;
            end
            modexp_pkg::OP_SET_SQR:
            begin
                x_next    = pw_reg;
                y_next    = pw_reg;
                prod_next = '0;
            end
            modexp_pkg::OP_NEXT_BIT:
            begin
                exp_next  = exp_reg >> 1;
                ecnt_next = (ecnt_reg == LAST_CNT) ? '0 : ecnt_reg + cnt_t'(1);
            end
            modexp_pkg::OP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = modexp_pkg::FIELD_BITS'(acc_reg);
                end
            end
            default:
            begin
                prod_next = prod_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= modexp_pkg::STEP_IDLE;
            out_valid_reg <= 1'b0;
            mcnt_reg      <= '0;
            ecnt_reg      <= '0;
            modulus_reg   <= word_t'(1);
            exponent_reg  <= word_t'(1);
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            mcnt_reg      <= mcnt_next;
            ecnt_reg      <= ecnt_next;
            modulus_reg   <= modulus_next;
            exponent_reg  <= exponent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        acc_reg      <= acc_next;
        pw_reg       <= pw_next;
        exp_reg      <= exp_next;
        out_data_reg <= out_data_next;
    end

`include "assert_macros.svh"

    `ASSERT_IMP(a_idle_cnt, pc_reg == modexp_pkg::STEP_IDLE, mcnt_reg == '0, "bit counter busy in idle")
    `ASSERT_IMP(a_reduced, pc_reg != modexp_pkg::STEP_IDLE, (prod_reg < m_eff) && (x_reg < m_eff) && (acc_reg < m_eff), "operand not reduced")
    `ASSERT_IMP(a_emit_src, $rose(out_valid_reg), $past(pc_reg) == modexp_pkg::STEP_EMIT, "result without emit step")
    `ASSERT_NXT(a_start, req_fire, pc_reg == modexp_pkg::STEP_REDUCE, "request did not start reduction")

endmodule

`default_nettype wire
